FILE: sv/fdm_pkg.sv
`default_nettype none
package fdm_pkg;

  // Largest frame edge in pixels; position counters are sized from it.
  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned POS_W   = $clog2(MAX_DIM);
  localparam int unsigned DIM_W   = POS_W + 1;

  // Register field widths
  localparam int unsigned THR_W  = 8;
  localparam int unsigned SIZE_W = 13;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 8'd8;
  localparam logic [SIZE_W-1:0] WIDTH_RST     = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST    = 13'd480;

  // Changed-pixel counter, saturating
  localparam int unsigned CNT_W = 25;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Classify queue between front and back (power of two)
  localparam int unsigned CQ_DEPTH = 4;
  localparam int unsigned CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int unsigned CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  // Result buffer (power of two)
  localparam int unsigned RB_DEPTH = 2;
  localparam int unsigned RB_PTR_W = $clog2(RB_DEPTH);
  localparam int unsigned RB_CNT_W = $clog2(RB_DEPTH + 1);

  // APB
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] old_red;
    logic [7:0] old_green;
    logic [7:0] old_blue;
    logic [7:0] new_red;
    logic [7:0] new_green;
    logic [7:0] new_blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0]       mask_red;
    logic [7:0]       mask_green;
    logic [7:0]       mask_blue;
    logic             pixel_changed;
    logic             frame_done;
    logic [CNT_W-1:0] changed_total;
    logic             any_changed;
    logic [POS_W-1:0] box_left;
    logic [POS_W-1:0] box_top;
    logic [DIM_W-1:0] box_right;
    logic [DIM_W-1:0] box_bottom;
  } result_t;

  // Classified pixel, handed from front to back
  typedef struct packed {
    logic             changed;
    logic [7:0]       dim_red;
    logic [7:0]       dim_green;
    logic [7:0]       dim_blue;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic             frame_done;
  } cmd_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // floor(v * 3 / 10) as (v * 615) >> 11, exact for all 8-bit v
  function automatic logic [7:0] dim3(input logic [7:0] v);
    logic [17:0] prod;
    prod = 18'(v) * 18'd615;
    return 8'(prod >> 11);
  endfunction

  // Zero acts as one, oversize clamps to MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [SIZE_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/fdm_front.sv
`default_nettype none
module fdm_front import fdm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire pixel_t            pixel_i,
  input  wire logic [THR_W-1:0]  threshold_i,
  input  wire logic [SIZE_W-1:0] width_i,
  input  wire logic [SIZE_W-1:0] height_i,
  output cmd_t                   cmd_o
);

  logic [POS_W-1:0] column_q, column_d;
  logic [POS_W-1:0] row_q, row_d;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [7:0]       dr, dg, db, dmax;
  logic             last_col, done;

  assign w_eff = eff_dim(width_i);
  assign h_eff = eff_dim(height_i);

  assign dr = abs_diff(pixel_i.old_red,   pixel_i.new_red);
  assign dg = abs_diff(pixel_i.old_green, pixel_i.new_green);
  assign db = abs_diff(pixel_i.old_blue,  pixel_i.new_blue);

  always_comb begin
    dmax = dr;
    if (dg > dmax) dmax = dg;
    if (db > dmax) dmax = db;
  end

  // Positions past a shrunk edge count as the last one
  assign last_col = (DIM_W'(column_q) + DIM_W'(1)) >= w_eff;
  assign done     = last_col && ((DIM_W'(row_q) + DIM_W'(1)) >= h_eff);

  always_comb begin
    cmd_o.changed    = dmax > threshold_i;
    cmd_o.dim_red    = dim3(pixel_i.new_red);
    cmd_o.dim_green  = dim3(pixel_i.new_green);
    cmd_o.dim_blue   = dim3(pixel_i.new_blue);
    cmd_o.column     = column_q;
    cmd_o.row        = row_q;
    cmd_o.frame_done = done;
  end

  always_comb begin
    column_d = column_q;
    row_d    = row_q;
    if (accept_i) begin
      if (last_col) begin
        column_d = '0;
        row_d    = done ? '0 : row_q + 1'b1;
      end else begin
        column_d = column_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
    end else begin
      column_q <= column_d;
      row_q    <= row_d;
    end
  end

endmodule
`default_nettype wire

FILE: sv/fdm_cmd_queue.sv
`default_nettype none
module fdm_cmd_queue import fdm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      cmd_o
);

  cmd_t                mem_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CQ_CNT_W-1:0] cnt_q;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == CQ_CNT_W'(CQ_DEPTH);
  assign empty_o = cnt_q == '0;
  assign cmd_o   = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/fdm_back.sv
`default_nettype none
module fdm_back import fdm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  input  wire logic pop,
  output logic      empty,
  output result_t   result_o
);

  // Frame summary
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             seen_q, seen_d;
  logic [POS_W-1:0] min_col_q, min_col_d, min_row_q, min_row_d;
  logic [POS_W-1:0] max_col_q, max_col_d, max_row_q, max_row_d;

  // Summary including the current pixel
  logic [CNT_W-1:0] cnt_n;
  logic             seen_n;
  logic [POS_W-1:0] min_col_n, min_row_n, max_col_n, max_row_n;

  // Result buffer
  result_t             rb_q [RB_DEPTH];
  logic [RB_PTR_W-1:0] rb_wr_q, rb_rd_q;
  logic [RB_CNT_W-1:0] rb_cnt_q;
  logic                rb_pop, rb_space, step;
  result_t             res;

  assign empty    = rb_cnt_q == '0;
  assign result_o = rb_q[rb_rd_q];
  assign rb_pop   = pop && !empty;
  assign rb_space = (rb_cnt_q != RB_CNT_W'(RB_DEPTH)) || rb_pop;
  assign step     = cmd_valid_i && rb_space;
  assign cmd_pop_o = step;

  always_comb begin
    cnt_n     = cnt_q;
    seen_n    = seen_q;
    min_col_n = min_col_q;
    min_row_n = min_row_q;
    max_col_n = max_col_q;
    max_row_n = max_row_q;
    if (cmd_i.changed) begin
      if (cnt_q != CNT_MAX) cnt_n = cnt_q + 1'b1;
      seen_n = 1'b1;
      if (!seen_q) begin
        min_col_n = cmd_i.column;
        min_row_n = cmd_i.row;
        max_col_n = cmd_i.column;
        max_row_n = cmd_i.row;
      end else begin
        if (cmd_i.column < min_col_q) min_col_n = cmd_i.column;
        if (cmd_i.row < min_row_q)    min_row_n = cmd_i.row;
        if (cmd_i.column > max_col_q) max_col_n = cmd_i.column;
        if (cmd_i.row > max_row_q)    max_row_n = cmd_i.row;
      end
    end
  end

  always_comb begin
    res = '0;
    res.pixel_changed = cmd_i.changed;
    res.frame_done    = cmd_i.frame_done;
    if (cmd_i.changed) begin
      res.mask_red   = 8'd255;
      res.mask_green = 8'd0;
      res.mask_blue  = 8'd255;
    end else begin
      res.mask_red   = cmd_i.dim_red;
      res.mask_green = cmd_i.dim_green;
      res.mask_blue  = cmd_i.dim_blue;
    end
    if (cmd_i.frame_done) begin
      res.changed_total = cnt_n;
      if (seen_n) begin
        res.any_changed = 1'b1;
        res.box_left    = min_col_n;
        res.box_top     = min_row_n;
        res.box_right   = DIM_W'(max_col_n) + DIM_W'(1);
        res.box_bottom  = DIM_W'(max_row_n) + DIM_W'(1);
      end
    end
  end

  // Last pixel reports, then the summary starts over
  always_comb begin
    cnt_d     = cnt_q;
    seen_d    = seen_q;
    min_col_d = min_col_q;
    min_row_d = min_row_q;
    max_col_d = max_col_q;
    max_row_d = max_row_q;
    if (step) begin
      if (cmd_i.frame_done) begin
        cnt_d     = '0;
        seen_d    = 1'b0;
        min_col_d = '0;
        min_row_d = '0;
        max_col_d = '0;
        max_row_d = '0;
      end else begin
        cnt_d     = cnt_n;
        seen_d    = seen_n;
        min_col_d = min_col_n;
        min_row_d = min_row_n;
        max_col_d = max_col_n;
        max_row_d = max_row_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      seen_q    <= 1'b0;
      min_col_q <= '0;
      min_row_q <= '0;
      max_col_q <= '0;
      max_row_q <= '0;
    end else begin
      cnt_q     <= cnt_d;
      seen_q    <= seen_d;
      min_col_q <= min_col_d;
      min_row_q <= min_row_d;
      max_col_q <= max_col_d;
      max_row_q <= max_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      rb_q[rb_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb_wr_q  <= '0;
      rb_rd_q  <= '0;
      rb_cnt_q <= '0;
    end else begin
      if (step)   rb_wr_q <= rb_wr_q + 1'b1;
      if (rb_pop) rb_rd_q <= rb_rd_q + 1'b1;
      if (step && !rb_pop) begin
        rb_cnt_q <= rb_cnt_q + 1'b1;
      end else if (rb_pop && !step) begin
        rb_cnt_q <= rb_cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/frame_difference_mask.sv
// Frame difference mask. Push one pixel pair (old and new RGB) per clock in
// raster order; the block tracks column and row from frame_width and
// frame_height (0 acts as 1, values above 4096 clamp to 4096). A pixel whose
// largest channel difference exceeds change_threshold comes out magenta and
// is counted into the frame's changed total and bounding box (right and
// bottom edges exclusive); any other pixel comes out as the new pixel dimmed
// to floor(3/10). The summary fields are nonzero only on the frame's last
// pixel (frame_done), after which the summary clears. Throughput is one
// pixel per clock sustained: the front classifies and positions a pixel in
// the cycle it is accepted, the back folds it into the summary as it writes
// the result buffer, and each side stalls on its own behind a 4-entry
// transaction queue and a 2-entry result buffer. A result goes through the
// queue and is registered in the result buffer before it shows on result_o,
// where it holds until popped. Configuration registers over APB:
// 0x0 change_threshold, 0x4 frame_width, 0x8 frame_height; write them only
// while the block is idle.
`default_nettype none
module frame_difference_mask import fdm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // pixel input, queue style
  input  wire logic              push,
  output logic                   full,
  input  wire pixel_t            pixel_i,
  // results, queue style
  output logic                   empty,
  input  wire logic              pop,
  output result_t                result_o,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  logic [THR_W-1:0]  threshold_q;
  logic [SIZE_W-1:0] width_q, height_q;
  reg_idx_e          reg_idx;
  logic              cfg_wr;

  logic accept;
  cmd_t front_cmd, back_cmd;
  logic cq_empty, cq_pop;

  // Register file: index from the word address, pready tied high
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RST;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_THRESHOLD: threshold_q <= pwdata[THR_W-1:0];
        REG_WIDTH:     width_q     <= pwdata[SIZE_W-1:0];
        REG_HEIGHT:    height_q    <= pwdata[SIZE_W-1:0];
        default: ;  // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = APB_DW'(threshold_q);
      REG_WIDTH:     prdata = APB_DW'(width_q);
      REG_HEIGHT:    prdata = APB_DW'(height_q);
      default:       prdata = '0;
    endcase
  end

  // Front: difference, threshold, dimming and raster position
  assign accept = push && !full;

  fdm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .pixel_i     (pixel_i),
    .threshold_i (threshold_q),
    .width_i     (width_q),
    .height_i    (height_q),
    .cmd_o       (front_cmd)
  );

  // Queue decoupling front from back; its fill sets full
  fdm_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (cq_pop),
    .empty_o (cq_empty),
    .cmd_o   (back_cmd)
  );

  // Back: frame summary and result buffer
  fdm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cq_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cq_pop),
    .pop         (pop),
    .empty       (empty),
    .result_o    (result_o)
  );

endmodule
`default_nettype wire

FILE: sv/fdm_checker.sv
`default_nettype none
module fdm_checker import fdm_pkg::*; (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    empty,
  input wire logic    pop,
  input wire logic    pready,
  input wire result_t result_o
);

  // A waiting result holds until taken
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("result changed or vanished before pop");

  a_changed_magenta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.pixel_changed) |->
      (result_o.mask_red == 8'd255 && result_o.mask_green == 8'd0 &&
       result_o.mask_blue == 8'd255))
    else $error("changed pixel not magenta");

  a_summary_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.frame_done) |->
      (result_o.changed_total == '0 && !result_o.any_changed &&
       result_o.box_right == '0 && result_o.box_bottom == '0))
    else $error("summary fields set before end of frame");

  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.any_changed) |->
      (result_o.box_right > DIM_W'(result_o.box_left) &&
       result_o.box_bottom > DIM_W'(result_o.box_top) &&
       result_o.changed_total != '0))
    else $error("bounding box empty or inverted");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind frame_difference_mask fdm_checker u_fdm_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .pready   (pready),
  .result_o (result_o)
);
`default_nettype wire
